FILE: rtl/dvrt_pkg.sv
// dvrt_pkg: shared constants and types for the distance-vector route table
// used by every rtl file of the block; no dependencies
`default_nettype none
package dvrt_pkg;
    localparam int TableDepth = 16;
    localparam int CntW = $clog2(TableDepth + 1);
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_ADVERT = 2'd2;
    localparam logic [1:0] OP_POISON = 2'd3;
    localparam logic [7:0] COST_INF = 8'd16;
    localparam logic [7:0] END_MARK = 8'd255;

    // one table entry as it sits in a cell
    typedef struct packed {
        logic       vld;
        logic [7:0] dest;
        logic [7:0] cost;
        logic [7:0] hop;
    } t_entry;

    // command broadcast to all cells
    typedef struct packed {
        logic       shift;  // rotate row toward cell 0
        logic       wr;     // write entry at index
        logic       kill;   // remove entry at index, close gap
        logic [7:0] idx;
        t_entry     ent;
    } t_cmd;
endpackage
`default_nettype wire

FILE: rtl/dvrt_cell.sv
// dvrt_cell: one slot of the route row; holds an entry, matches and shifts
// depends on dvrt_pkg
`default_nettype none
module dvrt_cell import dvrt_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_my_idx,
    input  wire t_cmd       i_cmd,
    input  wire t_entry     i_next,   // neighbor above
    input  wire logic [7:0] i_key,
    output t_entry          o_ent,
    output logic            o_hit
);
    t_entry r_ent, n_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_cmd.shift) begin
            n_ent = i_next;
        end else if (i_cmd.wr && i_cmd.idx == i_my_idx) begin
            n_ent = i_cmd.ent;
        end else if (i_cmd.kill && i_my_idx >= i_cmd.idx) begin
            n_ent = i_next;
            // top cell has nothing above it when closing a gap
            if (i_my_idx == 8'(TableDepth - 1)) begin
                n_ent.vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.vld <= 1'b0;
        end else begin
            r_ent.vld <= n_ent.vld;
        end
        r_ent.dest <= n_ent.dest;
        r_ent.cost <= n_ent.cost;
        r_ent.hop  <= n_ent.hop;
    end

    assign o_ent = r_ent;
    assign o_hit = r_ent.vld && r_ent.dest == i_key;
endmodule
`default_nettype wire

FILE: rtl/distance_vector_route_table_top.sv
// distance_vector_route_table_top: route table built as a row of dvrt_cell
// depends on dvrt_pkg and dvrt_cell
//
// input channel: one word per operation (op, neighbor, destination, cost)
// output channel: result words with last set on the final word of an operation
// update and lookup: match over all cells is combinational; the single result word
// is registered in S_MATCH after acceptance, and with a ready receiver the next
// operation is taken once the state has gone from S_DONE back to S_IDLE.
// advertise and poison: the row is rotated one cell per cycle toward cell 0,
// except while a pair is sent or waits on the receiver, for TableDepth visits;
// a visit that sends a pair passes through S_ROT and S_COST. header, pairs and
// a 255 trailer give 2*n + 2 words for n pairs. the next operation is taken
// only after the last word of the previous one has been accepted. a stalled
// receiver holds the output register and stops the rotation at the next entry
// to send. reset empties the row; entry payloads stay undefined.
`default_nettype none
module distance_vector_route_table_top import dvrt_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_neighbor_addr,
    input  wire logic [7:0]  i_dest_addr,
    input  wire logic [7:0]  i_adv_cost,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic [15:0]      o_lookup_word,
    output logic             o_changed,
    output logic             o_table_full,
    output logic             o_last
);
    localparam logic [2:0] S_IDLE = 3'd0, S_MATCH = 3'd1, S_HEAD = 3'd2,
                           S_ROT = 3'd3, S_COST = 3'd4, S_TAIL = 3'd5,
                           S_DONE = 3'd6;
    localparam int RotW = $clog2(TableDepth + 1);

    logic [2:0]      r_state, n_state;
    logic [1:0]      r_op;
    logic [7:0]      r_nb, r_dst, r_cst;
    logic [RotW-1:0] r_rot, n_rot;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_ov, n_ov;
    logic [7:0]      r_ob, n_ob;
    logic [15:0]     r_lw, n_lw;
    logic            r_ch, n_ch, r_tf, n_tf, r_la, n_la;
    t_cmd            cmd;

    t_entry          ents [TableDepth+1];
    logic [TableDepth-1:0] hits;

    assign ents[TableDepth] = '0;

    for (genvar g = 0; g < TableDepth; g++) begin : g_cell
        dvrt_cell u_cell (
            .i_clk, .i_rst_n,
            .i_my_idx(8'(g)),
            .i_cmd(cmd),
            .i_next(g == TableDepth - 1 ? ents[0] : ents[g+1]),
            .i_key(r_dst),
            .o_ent(ents[g]),
            .o_hit(hits[g])
        );
    end

    // first matching cell
    logic       any_hit;
    logic [7:0] hit_idx;
    t_entry     hit_ent;
    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        hit_ent = '0;
        for (int k = TableDepth - 1; k >= 0; k--) begin
            if (hits[k]) begin
                any_hit = 1'b1;
                hit_idx = 8'(k);
                hit_ent = ents[k];
            end
        end
    end

    logic [7:0] newc;
    logic       out_free, via;
    assign newc     = (r_cst == 8'hff) ? 8'hff : r_cst + 8'd1;
    assign out_free = !r_ov || i_ready;
    assign via      = ents[0].hop == r_nb;
    assign o_ready  = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        n_rot = r_rot;
        n_cnt = r_cnt;
        n_ov = r_ov && !i_ready;
        n_ob = r_ob; n_lw = r_lw; n_ch = r_ch; n_tf = r_tf; n_la = r_la;
        cmd = '0;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_MATCH;
            S_MATCH: if (out_free) begin
                n_ov = 1'b1; n_ob = '0; n_lw = '0; n_ch = 1'b0; n_tf = 1'b0;
                n_la = 1'b1;
                n_state = S_DONE;
                case (r_op)
                    OP_UPDATE: if (r_dst != END_MARK) begin
                        if (any_hit) begin
                            if (r_cst == COST_INF && hit_ent.hop == r_nb) begin
                                cmd.kill = 1'b1;
                                cmd.idx = hit_idx;
                                n_cnt = r_cnt - CntW'(1);
                                n_ch = 1'b1;
                            end else if (newc < hit_ent.cost) begin
                                cmd.wr = 1'b1;
                                cmd.idx = hit_idx;
                                cmd.ent = '{vld: 1'b1, dest: r_dst, cost: newc, hop: r_nb};
                                n_ch = 1'b1;
                            end
                        end else if (r_cst != COST_INF) begin
                            if (r_cnt < CntW'(TableDepth)) begin
                                cmd.wr = 1'b1;
                                cmd.idx = 8'(r_cnt);
                                cmd.ent = '{vld: 1'b1, dest: r_dst, cost: newc, hop: r_nb};
                                n_cnt = r_cnt + CntW'(1);
                                n_ch = 1'b1;
                            end else begin
                                n_tf = 1'b1;
                            end
                        end
                    end
                    OP_LOOKUP: if (any_hit) n_lw = {hit_ent.dest, hit_ent.hop};
                    default: begin
                        n_ov = 1'b0;
                        n_state = S_HEAD;
                    end
                endcase
            end
            S_HEAD: if (out_free) begin
                n_ov = 1'b1; n_ob = (r_op == OP_POISON) ? END_MARK : r_nb;
                n_lw = '0; n_ch = 1'b0; n_tf = 1'b0; n_la = 1'b0;
                n_rot = '0;
                n_state = S_ROT;
            end
            S_ROT: if (r_rot == RotW'(TableDepth)) begin
                if (out_free) begin
                    n_ov = 1'b1; n_ob = END_MARK; n_la = 1'b1;
                    n_state = S_DONE;
                end
            end else if (ents[0].vld && ((r_op == OP_POISON) == via)) begin
                if (out_free) begin
                    n_ov = 1'b1; n_ob = ents[0].dest;
                    n_state = S_COST;
                end
            end else begin
                cmd.shift = 1'b1;
                n_rot = r_rot + RotW'(1);
            end
            S_COST: if (out_free) begin
                n_ov = 1'b1;
                n_ob = (r_op == OP_POISON) ? COST_INF : ents[0].cost;
                cmd.shift = 1'b1;
                n_rot = r_rot + RotW'(1);
                n_state = S_ROT;
            end
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_ov <= n_ov;
        end
        if (i_valid && o_ready) begin
            r_op <= i_op; r_nb <= i_neighbor_addr;
            r_dst <= i_dest_addr; r_cst <= i_adv_cost;
        end
        r_rot <= n_rot;
        r_ob <= n_ob; r_lw <= n_lw; r_ch <= n_ch; r_tf <= n_tf; r_la <= n_la;
    end

    assign o_valid = r_ov;
    assign o_out_byte = r_ob;
    assign o_lookup_word = r_lw;
    assign o_changed = r_ch;
    assign o_table_full = r_tf;
    assign o_last = r_la;

`ifndef NO_ASSERTIONS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(TableDepth)) else $error("route count overflow");
    a_full_nochg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_ch && r_tf)) else $error("changed with table full");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_ov) else $error("word pending while idle");
`endif
endmodule
`default_nettype wire

FILE: test/dvrt_checker.sv
// dvrt_checker: watches both channels of the route table, predicts result words
// depends on dvrt_pkg; instantiated beside the block by the testbench top
`timescale 1ns / 1ps
module dvrt_checker import dvrt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_neighbor_addr,
    input  logic [7:0]  i_dest_addr,
    input  logic [7:0]  i_adv_cost,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic [15:0] i_lookup_word,
    input  logic        i_changed,
    input  logic        i_table_full,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] lookup_word;
        logic        changed;
        logic        table_full;
        logic        last;
    } t_result;

    t_result    route_results[$];
    logic [7:0] tbl_dest[TableDepth];
    logic [7:0] tbl_cost[TableDepth];
    logic [7:0] tbl_hop[TableDepth];
    int         tbl_count;

    function automatic t_result mk(logic [7:0] b, logic [15:0] w, logic c, logic f,
                                   logic l);
        t_result r;
        r.out_byte = b; r.lookup_word = w; r.changed = c; r.table_full = f;
        r.last = l;
        return r;
    endfunction

    task automatic predict_route_op(logic [1:0] op, logic [7:0] nb, logic [7:0] dst,
                                    logic [7:0] cost);
        logic [7:0]  newc;
        logic        chg, full, found, via;
        logic [15:0] word;
        chg = 0; full = 0; found = 0; word = 0;
        newc = (cost == 8'd255) ? 8'd255 : cost + 8'd1;
        case (op)
            OP_UPDATE: begin
                if (dst != END_MARK) begin
                    for (int i = 0; i < tbl_count && !found; i++) begin
                        if (tbl_dest[i] == dst) begin
                            found = 1;
                            if (cost == COST_INF && tbl_hop[i] == nb) begin
                                for (int j = i; j + 1 < tbl_count; j++) begin
                                    tbl_dest[j] = tbl_dest[j+1];
                                    tbl_cost[j] = tbl_cost[j+1];
                                    tbl_hop[j]  = tbl_hop[j+1];
                                end
                                tbl_count--;
                                chg = 1;
                            end else if (newc < tbl_cost[i]) begin
                                tbl_cost[i] = newc;
                                tbl_hop[i]  = nb;
                                chg = 1;
                            end
                        end
                    end
                    if (!found && cost != COST_INF) begin
                        if (tbl_count < TableDepth) begin
                            tbl_dest[tbl_count] = dst;
                            tbl_cost[tbl_count] = newc;
                            tbl_hop[tbl_count]  = nb;
                            tbl_count++;
                            chg = 1;
                        end else begin
                            full = 1;
                        end
                    end
                end
                route_results.push_back(mk(0, 0, chg, full, 1));
            end
            OP_LOOKUP: begin
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_dest[i] == dst) word = {tbl_dest[i], tbl_hop[i]};
                route_results.push_back(mk(0, word, 0, 0, 1));
            end
            default: begin
                route_results.push_back(mk(op == OP_POISON ? END_MARK : nb, 0, 0, 0, 0));
                for (int i = 0; i < tbl_count; i++) begin
                    via = (tbl_hop[i] == nb);
                    if ((op == OP_POISON) ? via : !via) begin
                        route_results.push_back(mk(tbl_dest[i], 0, 0, 0, 0));
                        route_results.push_back(mk(op == OP_POISON ? COST_INF : tbl_cost[i],
                                                   0, 0, 0, 0));
                    end
                end
                route_results.push_back(mk(END_MARK, 0, 0, 0, 1));
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            tbl_count <= 0;
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            // output side first: the word now leaving came from an earlier input
            if (i_out_valid && i_out_ready) begin
                if (route_results.size() == 0) begin
                    $display("%0t: unexpected word byte=%h word=%h chg=%b full=%b last=%b",
                             $time, i_out_byte, i_lookup_word, i_changed, i_table_full,
                             i_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = route_results.pop_front();
                    if (want !== {i_out_byte, i_lookup_word, i_changed, i_table_full,
                                  i_last}) begin
                        $display("%0t: mismatch expected byte=%h word=%h chg=%b full=%b last=%b",
                                 $time, want.out_byte, want.lookup_word, want.changed,
                                 want.table_full, want.last);
                        $display("%0t:          actual   byte=%h word=%h chg=%b full=%b last=%b",
                                 $time, i_out_byte, i_lookup_word, i_changed,
                                 i_table_full, i_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_route_op(i_op, i_neighbor_addr, i_dest_addr, i_adv_cost);
            o_pending <= route_results.size();
        end
    end
endmodule

FILE: test/tb_distance_vector_route_table_top.sv
// tb_distance_vector_route_table_top: stimulus, pacing and verdict for the route table
// depends on dvrt_pkg, distance_vector_route_table_top and dvrt_checker
`timescale 1ns / 1ps
module tb_distance_vector_route_table_top;
    import dvrt_pkg::*;

    logic        i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    logic [1:0]  i_op;
    logic [7:0]  i_neighbor_addr, i_dest_addr, i_adv_cost, o_out_byte;
    logic [15:0] o_lookup_word;
    logic        o_changed, o_table_full, o_last;
    int          fail_count, pending_words, cycle_count = 0;
    logic        long_hold;
    logic [7:0]  nbr_pool[4] = '{8'd1, 8'd2, 8'd3, 8'd200};

    distance_vector_route_table_top u_dut (.*);

    dvrt_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid(i_valid), .i_in_ready(o_ready), .i_op,
        .i_neighbor_addr, .i_dest_addr, .i_adv_cost, .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_out_byte(o_out_byte), .i_lookup_word(o_lookup_word),
        .i_changed(o_changed), .i_table_full(o_table_full), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending_words)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: own stall pattern, plus a long hold-off when asked
    initial begin
        i_ready = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) i_ready <= 0;
            else if (cycle_count % 97 < 30) i_ready <= 1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_word(logic [1:0] op, logic [7:0] nb, logic [7:0] dst,
                             logic [7:0] cost);
        i_valid <= 1; i_op <= op; i_neighbor_addr <= nb; i_dest_addr <= dst;
        i_adv_cost <= cost;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(int n);
        i_valid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending_words != 0) @(negedge i_clk);
        repeat (TableDepth + 8) @(negedge i_clk);
    endtask

    initial begin
        logic [1:0] op;
        logic [7:0] d;
        int         burst;
        long_hold = 0;
        i_valid = 0; i_op = OP_UPDATE; i_neighbor_addr = 0; i_dest_addr = 0;
        i_adv_cost = 0; i_rst_n = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty streams, extremes, removal, cheaper, terminator
        send_word(OP_ADVERT, 8'd0, 8'd0, 8'd0);
        send_word(OP_POISON, 8'd255, 8'd0, 8'd0);
        send_word(OP_LOOKUP, 8'd0, 8'd0, 8'd0);
        send_word(OP_UPDATE, 8'd0, 8'd0, 8'd0);
        send_word(OP_UPDATE, 8'd255, 8'd254, 8'd255);
        send_word(OP_UPDATE, 8'd7, 8'd255, 8'd3);
        send_word(OP_UPDATE, 8'd7, 8'd10, 8'd16);
        send_word(OP_UPDATE, 8'd7, 8'd10, 8'd9);
        send_word(OP_UPDATE, 8'd8, 8'd10, 8'd2);
        send_word(OP_UPDATE, 8'd8, 8'd10, 8'd5);
        send_word(OP_LOOKUP, 8'd0, 8'd10, 8'd0);
        send_word(OP_ADVERT, 8'd8, 8'd0, 8'd0);
        send_word(OP_POISON, 8'd8, 8'd0, 8'd0);
        send_word(OP_UPDATE, 8'd7, 8'd10, 8'd16);
        send_word(OP_UPDATE, 8'd8, 8'd0, 8'd16);
        send_word(OP_UPDATE, 8'd8, 8'd10, 8'd16);
        send_word(OP_LOOKUP, 8'd0, 8'd10, 8'd0);
        // fill past capacity
        for (int i = 0; i < TableDepth + 2; i++)
            send_word(OP_UPDATE, nbr_pool[i % 4], 8'(20 + i), 8'($urandom_range(0, 20)));
        send_word(OP_ADVERT, 8'd1, 8'd0, 8'd0);
        send_word(OP_POISON, 8'd2, 8'd0, 8'd0);

        // sender pauses until every word has come
        drain();

        // long receiver hold-off while offering words
        long_hold = 1;
        fork
            begin
                repeat (60) @(negedge i_clk);
                long_hold = 0;
            end
            for (int i = 0; i < 6; i++)
                send_word(OP_LOOKUP, 8'($urandom), 8'(20 + i), 8'($urandom));
        join
        drain();

        // random: mostly updates on a small address pool so the table churns
        for (int n = 0; n < 90; ) begin
            burst = $urandom_range(1, 10);
            for (int b = 0; b < burst; b++, n++) begin
                d = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(30, 50));
                case ($urandom_range(0, 9))
                    0, 1: op = OP_LOOKUP;
                    2: op = OP_ADVERT;
                    3: op = OP_POISON;
                    default: op = OP_UPDATE;
                endcase
                send_word(op, ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                         : nbr_pool[$urandom_range(0, 3)],
                          d, ($urandom_range(0, 2) == 0) ? COST_INF : 8'($urandom));
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
        end
        drain();

        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

FILE: sim.f
rtl/dvrt_pkg.sv
rtl/dvrt_cell.sv
rtl/distance_vector_route_table_top.sv
test/dvrt_checker.sv
test/tb_distance_vector_route_table_top.sv
